/* rtl/core/pfim_pkg.sv */
package pfim_pkg;

  // field and datapath widths
  localparam int FIELD_W   = 16;
  localparam int DIV_W     = 32;
  localparam int DVSR_W    = 16;
  localparam int COEF_W    = 18;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int CFG_IDX_W = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_N = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_M = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SCATTER  = CFG_IDX_W'(3);

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOT_COPRIME,
    ST_TOO_LARGE,
    ST_RANGE
  } status_t;

  typedef struct packed {
    logic [FIELD_W-1:0] row_index;
    logic [FIELD_W-1:0] col_index;
  } in_beat_t;

  typedef struct packed {
    logic [FIELD_W-1:0] in_map_position;
    logic [FIELD_W-1:0] in_map_value;
    logic [FIELD_W-1:0] out_map_position;
    logic [FIELD_W-1:0] out_map_value;
    status_t            status;
  } out_beat_t;

  typedef struct packed {
    logic [FIELD_W-1:0] factor_n;
    logic [FIELD_W-1:0] factor_m;
    logic               inverse_mode;
    logic               scatter_mode;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic ready;
    logic res_valid;
  } core_stat_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quot;
    logic [DVSR_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SETUP,
    S_GCD,
    S_GCD_WAIT,
    S_GCD_S,
    S_GCD_T,
    S_GCD_END,
    S_LEN,
    S_NORM,
    S_CHECK,
    S_IM,
    S_JN,
    S_IA,
    S_IA_WAIT,
    S_JB,
    S_JB_WAIT,
    S_MA,
    S_NB,
    S_POS,
    S_SEL,
    S_SEL_WAIT,
    S_OUT
  } state_t;

endpackage

/* rtl/core/pfim_divider.sv */
module pfim_divider import pfim_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_W);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  count;
  logic [DIV_W-1:0]  dvd;
  logic [DVSR_W-1:0] rem;
  logic [DVSR_W-1:0] dvsr;
  logic [DVSR_W:0]   trial;
  logic              fits;

  // one restoring step: shift in the next dividend bit, try a subtract
  always_comb begin
    trial = {rem, dvd[DIV_W-1]} - {1'b0, dvsr};
    fits  = !trial[DVSR_W];
  end

  // control: one quotient bit per cycle, done pulses after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CNT_W'(1);
        if (count == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient builds up in the dividend shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd  <= req.dividend;
      rem  <= '0;
      dvsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? trial[DVSR_W-1:0] : {rem[DVSR_W-2:0], dvd[DIV_W-1]};
      dvd <= {dvd[DIV_W-2:0], fits};
    end
  end

  assign rsp = '{done: done, quot: dvd, rem: rem};

endmodule

/* rtl/core/pfim_core.sv */
module pfim_core import pfim_pkg::*; #(
  parameter int LEN_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       cfg_clear,
  input  in_beat_t   in_beat,
  input  logic       in_take,
  input  logic       res_take,
  output core_stat_t stat,
  output out_beat_t  res
);

  localparam int LENW = LEN_BITS + 1;
  localparam logic [PROD_W-1:0] LEN_LIMIT = PROD_W'(1) << LEN_BITS;

  state_t  state, state_next;
  logic    ready;
  status_t setup_status;
  status_t st;
  status_t chk_status;

  logic [FIELD_W-1:0] row, col, minv, ninv, quo, part_a, part_b;
  logic [FIELD_W-1:0] r0, r1, off;
  logic signed [COEF_W-1:0] s0, s1, t0, t1;
  logic signed [COEF_W-1:0] n_s, m_s, t_wrap, s_wrap, t_norm, s_norm;
  logic [LENW-1:0] len, im, jn, cterm, dterm, ruri, lin, crt, oval, pos, val;
  logic [LENW-1:0] ruri_sum, crt_sum, pos_sel, val_sel, pos_fix;

  logic signed [COEF_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_u;

  logic     zero_factor, out_of_range, too_large, setup_done;
  div_req_t div_req;
  div_rsp_t div_rsp;

  pfim_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // shared multiplier
  assign prod   = mul_a * mul_b;
  assign prod_u = $unsigned(prod);

  // setup and item checks
  assign zero_factor  = (cfg.factor_n == '0) || (cfg.factor_m == '0);
  assign out_of_range = (row >= cfg.factor_n) || (col >= cfg.factor_m);
  assign too_large    = prod_u > LEN_LIMIT;

  always_comb begin
    if (setup_status != ST_OK) begin
      chk_status = setup_status;
    end else if (out_of_range) begin
      chk_status = ST_RANGE;
    end else begin
      chk_status = ST_OK;
    end
  end

  // bezout coefficients folded into [0, modulus)
  always_comb begin
    n_s    = $signed({2'b00, cfg.factor_n});
    m_s    = $signed({2'b00, cfg.factor_m});
    t_wrap = t0[COEF_W-1] ? t0 + n_s : t0;
    s_wrap = s0[COEF_W-1] ? s0 + m_s : s0;
    t_norm = (t_wrap >= n_s) ? t_wrap - n_s : t_wrap;
    s_norm = (s_wrap >= m_s) ? s_wrap - m_s : s_wrap;
  end

  // map arithmetic
  always_comb begin
    ruri_sum = im + jn;
    crt_sum  = cterm + dterm;
    pos_sel  = cfg.scatter_mode ? ruri : lin;
    val_sel  = cfg.scatter_mode ? lin : ruri;
    off      = (div_rsp.rem != '0) ? cfg.factor_n - div_rsp.rem : '0;
    pos_fix  = pos - LENW'(div_rsp.rem) + LENW'(off);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_take) state_next = ready ? S_CHECK : S_SETUP;
      S_SETUP:    state_next = zero_factor ? S_CHECK : S_GCD;
      S_GCD:      state_next = (r1 == '0) ? S_GCD_END : S_GCD_WAIT;
      S_GCD_WAIT: if (div_rsp.done) state_next = S_GCD_S;
      S_GCD_S:    state_next = S_GCD_T;
      S_GCD_T:    state_next = S_GCD;
      S_GCD_END:  state_next = (r0 == FIELD_W'(1)) ? S_LEN : S_CHECK;
      S_LEN:      state_next = too_large ? S_CHECK : S_NORM;
      S_NORM:     state_next = S_CHECK;
      S_CHECK:    state_next = (chk_status != ST_OK) ? S_OUT : S_IM;
      S_IM:       state_next = S_JN;
      S_JN:       state_next = S_IA;
      S_IA:       state_next = S_IA_WAIT;
      S_IA_WAIT:  if (div_rsp.done) state_next = S_JB;
      S_JB:       state_next = S_JB_WAIT;
      S_JB_WAIT:  if (div_rsp.done) state_next = S_MA;
      S_MA:       state_next = S_NB;
      S_NB:       state_next = S_POS;
      S_POS:      state_next = S_SEL;
      S_SEL:      state_next = cfg.inverse_mode ? S_SEL_WAIT : S_OUT;
      S_SEL_WAIT: if (div_rsp.done) state_next = S_OUT;
      S_OUT:      if (res_take) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands and divider requests
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_req = '{start: 1'b0, dividend: '0, divisor: '0};
    case (state)
      S_GCD: begin
        div_req = '{start: (r1 != '0), dividend: DIV_W'(r0), divisor: r1};
      end
      S_GCD_S: begin
        mul_a = $signed({2'b00, quo});
        mul_b = s1;
      end
      S_GCD_T: begin
        mul_a = $signed({2'b00, quo});
        mul_b = t1;
      end
      S_LEN: begin
        mul_a = n_s;
        mul_b = m_s;
      end
      S_IM: begin
        mul_a = $signed({2'b00, row});
        mul_b = m_s;
      end
      S_JN: begin
        mul_a = $signed({2'b00, col});
        mul_b = n_s;
      end
      S_IA: begin
        mul_a   = $signed({2'b00, row});
        mul_b   = $signed({2'b00, minv});
        div_req = '{start: 1'b1, dividend: prod_u[DIV_W-1:0], divisor: cfg.factor_n};
      end
      S_JB: begin
        mul_a   = $signed({2'b00, col});
        mul_b   = $signed({2'b00, ninv});
        div_req = '{start: 1'b1, dividend: prod_u[DIV_W-1:0], divisor: cfg.factor_m};
      end
      S_MA: begin
        mul_a = m_s;
        mul_b = $signed({2'b00, part_a});
      end
      S_NB: begin
        mul_a = n_s;
        mul_b = $signed({2'b00, part_b});
      end
      S_SEL: begin
        div_req = '{start: cfg.inverse_mode, dividend: DIV_W'(pos_sel),
                    divisor: cfg.factor_n};
      end
      default: begin
      end
    endcase
  end

  assign setup_done = (state != S_IDLE) && (state_next == S_CHECK);

  assign stat = '{busy: (state != S_IDLE), ready: ready, res_valid: (state == S_OUT)};
  assign res  = '{in_map_position: FIELD_W'(pos), in_map_value: FIELD_W'(val),
                  out_map_position: FIELD_W'(crt), out_map_value: FIELD_W'(oval),
                  status: st};

  // control state and cached setup results
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ready        <= 1'b0;
      setup_status <= ST_OK;
      minv         <= '0;
      ninv         <= '0;
    end else begin
      state <= state_next;
      if (cfg_clear) begin
        ready <= 1'b0;
      end else if (setup_done) begin
        ready <= 1'b1;
      end
      case (state)
        S_SETUP: begin
          minv <= '0;
          ninv <= '0;
          if (zero_factor) setup_status <= ST_NOT_COPRIME;
        end
        S_GCD_END: if (r0 != FIELD_W'(1)) setup_status <= ST_NOT_COPRIME;
        S_LEN:     if (too_large) setup_status <= ST_TOO_LARGE;
        S_NORM: begin
          setup_status <= ST_OK;
          minv         <= t_norm[FIELD_W-1:0];
          ninv         <= s_norm[FIELD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      row <= in_beat.row_index;
      col <= in_beat.col_index;
    end
    case (state)
      S_SETUP: begin
        r0 <= cfg.factor_n;
        r1 <= cfg.factor_m;
        s0 <= COEF_W'(1);
        s1 <= '0;
        t0 <= '0;
        t1 <= COEF_W'(1);
      end
      S_GCD_WAIT: begin
        if (div_rsp.done) begin
          quo <= div_rsp.quot[FIELD_W-1:0];
          r0  <= r1;
          r1  <= div_rsp.rem;
        end
      end
      S_GCD_S: begin
        s0 <= s1;
        s1 <= s0 - $signed(prod[COEF_W-1:0]);
      end
      S_GCD_T: begin
        t0 <= t1;
        t1 <= t0 - $signed(prod[COEF_W-1:0]);
      end
      S_LEN: len <= prod_u[LENW-1:0];
      S_CHECK: begin
        st <= chk_status;
        if (chk_status != ST_OK) begin
          pos  <= '0;
          val  <= '0;
          crt  <= '0;
          oval <= '0;
        end
      end
      S_IM:      im <= prod_u[LENW-1:0];
      S_JN:      jn <= prod_u[LENW-1:0];
      S_IA_WAIT: if (div_rsp.done) part_a <= div_rsp.rem;
      S_JB_WAIT: if (div_rsp.done) part_b <= div_rsp.rem;
      S_MA:      cterm <= prod_u[LENW-1:0];
      S_NB:      dterm <= prod_u[LENW-1:0];
      S_POS: begin
        ruri <= (ruri_sum >= len) ? ruri_sum - len : ruri_sum;
        crt  <= (crt_sum >= len) ? crt_sum - len : crt_sum;
        lin  <= jn + LENW'(row);
        oval <= im + LENW'(col);
      end
      S_SEL: begin
        pos <= pos_sel;
        val <= val_sel;
      end
      S_SEL_WAIT: if (div_rsp.done) pos <= pos_fix;
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/prime_factor_fft_index_maps.sv */
// Prime-factor FFT index maps: one result beat for each input beat.
// The divider passes (32 steps each) set most of the latency from input
// acceptance to out_valid; inverse_mode adds a third pass, and items with a
// nonzero status skip the map passes. One item at a time: in_stall stays high
// until the result is taken. After a write to a known register the first item
// also runs the Euclid setup, one divider pass per remainder step. Reset (rst,
// synchronous) sets factors to 1, modes to 0 and marks the cached inverses stale.
module prime_factor_fft_index_maps import pfim_pkg::*; #(
  parameter int LEN_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data
);

  cfg_t       cfg;
  logic       cfg_clear;
  logic       in_take;
  logic       res_take;
  core_stat_t stat;
  out_beat_t  res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{factor_n: FIELD_W'(1), factor_m: FIELD_W'(1),
               inverse_mode: 1'b0, scatter_mode: 1'b0};
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FACTOR_N: cfg.factor_n     <= cfg_data;
        REG_FACTOR_M: cfg.factor_m     <= cfg_data;
        REG_INVERSE:  cfg.inverse_mode <= cfg_data[0];
        REG_SCATTER:  cfg.scatter_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // any known register write invalidates the cached inverses
  assign cfg_clear = cfg_write && (cfg_index <= REG_SCATTER);

  assign in_stall = stat.busy;
  assign in_take  = in_valid && !in_stall;
  assign res_take = stat.res_valid && (!out_valid || !out_stall);

  pfim_core #(
    .LEN_BITS (LEN_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_clear (cfg_clear),
    .in_beat   (in_data),
    .in_take   (in_take),
    .res_take  (res_take),
    .stat      (stat),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_data <= res;
  end

  // an accepted beat always occupies the sequencer next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("sequencer not busy after input beat");

  // a known register write always invalidates the cached inverses
  a_cfg_clears_cache: assert property (@(posedge clk) disable iff (rst)
    cfg_clear |=> !stat.ready)
    else $error("cache still valid after register write");

  // error beats carry only a status
  a_error_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_OK) |->
      (out_data.in_map_position == '0) && (out_data.in_map_value == '0) &&
      (out_data.out_map_position == '0) && (out_data.out_map_value == '0))
    else $error("nonzero field on error beat");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import pfim_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(9);
  localparam int PHASES          = 23;
  localparam int BEATS_PER_PHASE = 40;
  localparam int SETTLE_CYCLES   = 150;

  // expected index-map beats, kept in acceptance order
  class index_map_board;
    localparam int LEN_BITS     = 16;
    localparam int REPORT_LINES = 40;

    logic [FIELD_W-1:0] fac_n     = 1;
    logic [FIELD_W-1:0] fac_m     = 1;
    logic               inv_mode  = 1'b0;
    logic               scat_mode = 1'b0;
    longint             m_inv     = 0;
    longint             n_inv     = 0;
    bit                 cache_ok  = 1'b0;
    status_t            setup_st  = ST_OK;
    out_beat_t          pending[$];
    int                 errors    = 0;

    function longint unsigned gcd(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    // extended euclid; modulus of one or less has inverse zero
    function longint mod_inverse(longint a, longint md);
      longint r0, r1, t0, t1, q, tmp;
      if (md <= 1) return 0;
      r0 = md;
      r1 = a % md;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
        q   = r0 / r1;
        tmp = r0 - q * r1;
        r0  = r1;
        r1  = tmp;
        tmp = t0 - q * t1;
        t0  = t1;
        t1  = tmp;
      end
      if (r0 != 1) return 0;
      if (t0 < 0) t0 = t0 + md;
      return t0;
    endfunction

    // any known register write marks the cached inverses stale
    function void note_write(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
      case (idx)
        REG_FACTOR_N: fac_n = data;
        REG_FACTOR_M: fac_m = data;
        REG_INVERSE:  inv_mode = data[0];
        REG_SCATTER:  scat_mode = data[0];
        default:      return;
      endcase
      cache_ok = 1'b0;
    endfunction

    function void refresh_cache();
      longint unsigned len;
      len   = longint'(fac_n) * longint'(fac_m);
      m_inv = 0;
      n_inv = 0;
      if (fac_n == 0 || fac_m == 0 || gcd(fac_n, fac_m) != 1) begin
        setup_st = ST_NOT_COPRIME;
      end else if (len > (longint'(1) << LEN_BITS)) begin
        setup_st = ST_TOO_LARGE;
      end else begin
        setup_st = ST_OK;
        m_inv    = mod_inverse(fac_m, fac_n);
        n_inv    = mod_inverse(fac_n, fac_m);
      end
      cache_ok = 1'b1;
    endfunction

    function out_beat_t predict_maps(in_beat_t b);
      longint unsigned i, j, n, m, len, ruri, lin, pos, val, off, crt;
      out_beat_t r;
      status_t st;
      if (!cache_ok) refresh_cache();
      i  = b.row_index;
      j  = b.col_index;
      n  = fac_n;
      m  = fac_m;
      st = setup_st;
      if (st == ST_OK && (i >= n || j >= m)) st = ST_RANGE;
      r        = '0;
      r.status = st;
      if (st != ST_OK) return r;
      len  = n * m;
      ruri = (i * m + j * n) % len;
      lin  = j * n + i;
      pos  = scat_mode ? ruri : lin;
      val  = scat_mode ? lin : ruri;
      // reverse the non-dc slots of each row
      if (inv_mode) begin
        off = pos % n;
        if (off != 0) off = n - off;
        pos = (pos / n) * n + off;
      end
      crt = ((i * m % len) * longint'(m_inv) + (j * n % len) * longint'(n_inv)) % len;
      r.in_map_position  = pos[FIELD_W-1:0];
      r.in_map_value     = val[FIELD_W-1:0];
      r.out_map_position = crt[FIELD_W-1:0];
      r.out_map_value    = FIELD_W'(i * m + j);
      return r;
    endfunction

    function void note_input(in_beat_t b);
      pending.push_back(predict_maps(b));
    endfunction

    task report_mismatch(string what, logic [FIELD_W-1:0] got_v, logic [FIELD_W-1:0] exp_v);
      if (errors < REPORT_LINES)
        $display("mismatch %s: got %0d expected %0d at %0t", what, got_v, exp_v, $time);
      errors++;
    endtask

    task check_result(out_beat_t got);
      out_beat_t want;
      if (pending.size() == 0) begin
        report_mismatch("beat with nothing expected, out_map_value", got.out_map_value, '0);
        return;
      end
      want = pending.pop_front();
      if (got.in_map_position !== want.in_map_position)
        report_mismatch("in_map_position", got.in_map_position, want.in_map_position);
      if (got.in_map_value !== want.in_map_value)
        report_mismatch("in_map_value", got.in_map_value, want.in_map_value);
      if (got.out_map_position !== want.out_map_position)
        report_mismatch("out_map_position", got.out_map_position, want.out_map_position);
      if (got.out_map_value !== want.out_map_value)
        report_mismatch("out_map_value", got.out_map_value, want.out_map_value);
      if (got.status !== want.status)
        report_mismatch("status", got.status, want.status);
    endtask
  endclass

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_beat_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0]   cfg_data  = '0;

  int send_idle = 0;
  int stall_pct = 0;

  index_map_board board;

  prime_factor_fft_index_maps DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) board.check_result(out_data);
  end

  // one input beat; called and returning at a falling edge
  task automatic send_beat(logic [FIELD_W-1:0] i, logic [FIELD_W-1:0] j);
    in_beat_t b;
    b.row_index = i;
    b.col_index = j;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_input(b);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    board.note_write(idx, data);
    @(negedge clk);
  endtask

  // mode bits carry random upper bits, which the block must ignore
  task automatic apply_settings(logic [FIELD_W-1:0] n, logic [FIELD_W-1:0] m,
                                logic inv, logic scat, bit spare);
    write_reg(REG_FACTOR_N, n);
    write_reg(REG_FACTOR_M, m);
    write_reg(REG_INVERSE, {15'($urandom_range(32767)), inv});
    write_reg(REG_SCATTER, {15'($urandom_range(32767)), scat});
    if (spare) write_reg(REG_SPARE, 16'($urandom_range(65535)));
    cfg_write <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0:       begin send_idle = 0;  stall_pct = 0;  end
      1:       begin send_idle = 60; stall_pct = 0;  end
      2:       begin send_idle = 0;  stall_pct = 60; end
      default: begin send_idle = 26; stall_pct = 26; end
    endcase
  endtask

  initial begin
    #16_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [FIELD_W-1:0] n, m, i, j;
    int sel, kind;
    board = new;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // unit factors straight out of reset
    send_beat(0, 0);
    send_beat(1, 0);
    send_beat(16'hFFFF, 16'hFFFF);
    drain();

    // small coprime pairs: gather, scatter with row reversal, gather with row reversal
    apply_settings(3, 5, 1'b0, 1'b0, 1'b0);
    send_beat(0, 0);
    send_beat(2, 4);
    send_beat(1, 3);
    send_beat(3, 0);
    send_beat(0, 5);
    drain();
    apply_settings(3, 5, 1'b1, 1'b1, 1'b0);
    send_beat(2, 4);
    send_beat(1, 2);
    send_beat(0, 0);
    drain();
    apply_settings(5, 3, 1'b1, 1'b0, 1'b0);
    send_beat(4, 2);
    send_beat(1, 1);
    drain();

    // largest lengths that still fit
    apply_settings(16'hFFFF, 1, 1'b1, 1'b0, 1'b0);
    send_beat(16'hFFFE, 0);
    send_beat(0, 0);
    send_beat(16'hFFFF, 0);
    drain();
    apply_settings(1, 16'hFFFF, 1'b0, 1'b1, 1'b0);
    send_beat(0, 16'hFFFE);
    drain();
    apply_settings(256, 255, 1'b1, 1'b1, 1'b0);
    send_beat(255, 254);
    send_beat(17, 100);
    drain();

    // not coprime wins over out of range; zero factor
    apply_settings(6, 4, 1'b0, 1'b0, 1'b0);
    send_beat(0, 0);
    send_beat(9, 9);
    drain();
    apply_settings(0, 7, 1'b0, 1'b0, 1'b0);
    send_beat(0, 0);
    drain();

    // length too large wins over out of range
    apply_settings(257, 256, 1'b0, 1'b1, 1'b0);
    send_beat(0, 0);
    send_beat(300, 0);
    drain();

    // write to an unused index keeps the settings
    apply_settings(7, 9, 1'b0, 1'b0, 1'b0);
    send_beat(3, 4);
    drain();
    write_reg(REG_SPARE, 16'hA5A5);
    cfg_write <= 1'b0;
    send_beat(6, 8);
    drain();

    // random phases, rotating the idling pattern
    for (int p = 0; p < PHASES; p++) begin
      sel = (p == 0 || p == PHASES - 1) ? 0 : $urandom_range(9);
      if (sel == 0) begin
        case ($urandom_range(5))
          0:       begin n = 16'hFFFF; m = 1;        end
          1:       begin n = 1;        m = 16'hFFFF; end
          2:       begin n = 256;      m = 255;      end
          3:       begin n = 255;      m = 256;      end
          4:       begin n = 4369;     m = 15;       end
          default: begin n = 1;        m = 1;        end
        endcase
      end else if (sel == 1) begin
        n = 16'($urandom_range(1, 30) * 6);
        m = 16'($urandom_range(0, 30) * 4);
      end else if (sel == 2) begin
        n = 16'($urandom_range(257, 65535));
        m = 16'($urandom_range(257, 65535));
      end else begin
        do begin
          n = 16'($urandom_range(1, 150));
          m = 16'($urandom_range(1, 150));
        end while (board.gcd(n, m) != 1);
      end
      apply_settings(n, m, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     $urandom_range(3) == 0);
      set_idling(p % 4);
      repeat (BEATS_PER_PHASE) begin
        i    = 16'($urandom_range(65535));
        j    = 16'($urandom_range(65535));
        kind = $urandom_range(19);
        case (kind)
          0, 1: ;  // noise over the full field range
          2: begin
            i = n;
            if (m != 0) j = 16'($urandom_range(m - 1));
          end
          3: begin
            j = m;
            if (n != 0) i = 16'($urandom_range(n - 1));
          end
          4: begin
            i = n - 16'd1;
            j = m - 16'd1;
          end
          default: begin
            if (n != 0) i = 16'($urandom_range(n - 1));
            if (m != 0) j = 16'($urandom_range(m - 1));
          end
        endcase
        send_beat(i, j);
      end
      drain();
    end

    set_idling(0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (board.pending.size() != 0)
      board.report_mismatch("beats never delivered, count", 16'(board.pending.size()), '0);
    if (board.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
